// ===== src/cfs_pkg.sv =====
// Shared types and constants for the CAN frame serializer with CRC-15.
`default_nettype none

package cfs_pkg;

    // Width of the frame bit counter; a frame is at most 111 bits long.
    localparam int POS_W = 7;

    // Frame layout constants.
    localparam logic [POS_W-1:0] HDR_BITS  = 7'd19;
    localparam logic [POS_W-1:0] CRC_BITS  = 7'd15;
    localparam logic [POS_W-1:0] TAIL_BITS = 7'd13;

    // CAN CRC-15 generator polynomial (x^15 term implied).
    localparam logic [14:0] CRC_POLY = 15'h4599;

    // Controller states, one per section of the frame.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HDR,
        ST_DATA,
        ST_CRC,
        ST_TAIL
    } state_t;

    // Source of the frame bit shifted out in the current cycle.
    typedef enum logic [1:0] {
        SRC_HDR,
        SRC_DATA,
        SRC_CRC,
        SRC_TAIL
    } bit_src_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     load;
        logic     step;
        bit_src_t sel;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic step_ok;
        logic phase_last;
        logic data_empty;
    } status_t;

endpackage

`default_nettype wire

// ===== src/cfs_if.sv =====
// Handshake channels: frame request in, bit chunks out.
`default_nettype none

interface cfs_req_if;
    logic        valid;
    logic        ready;
    logic [10:0] frame_id;
    logic [3:0]  data_length;
    logic [63:0] payload;

    modport source (output valid, output frame_id, output data_length, output payload,
                    input ready);
    modport sink   (input valid, input frame_id, input data_length, input payload,
                    output ready);
endinterface

interface cfs_chunk_if;
    logic       valid;
    logic       ready;
    logic [7:0] chunk_bits;
    logic [3:0] bit_count;
    logic       last;

    modport source (output valid, output chunk_bits, output bit_count, output last,
                    input ready);
    modport sink   (input valid, input chunk_bits, input bit_count, input last,
                    output ready);
endinterface

`default_nettype wire

// ===== src/cfs_ctrl.sv =====
// Frame sequencer: walks header, data, CRC and trailer one bit per step.
`default_nettype none

module cfs_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cfs_pkg::status_t status,
    output cfs_pkg::cmd_t        cmd
);

    cfs_pkg::state_t state_reg;
    cfs_pkg::state_t state_next;
    logic            busy;
    logic            advance;

    // A bit moves only in a frame section and when the datapath can take it.
    assign busy    = (state_reg != cfs_pkg::ST_IDLE);
    assign advance = busy && status.step_ok;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cfs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state: each section ends on its last bit.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cfs_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cfs_pkg::ST_HDR;
                end
            end
            cfs_pkg::ST_HDR:
            begin
                if (advance && status.phase_last)
                begin
                    state_next = status.data_empty ? cfs_pkg::ST_CRC : cfs_pkg::ST_DATA;
                end
            end
            cfs_pkg::ST_DATA:
            begin
                if (advance && status.phase_last)
                begin
                    state_next = cfs_pkg::ST_CRC;
                end
            end
            cfs_pkg::ST_CRC:
            begin
                if (advance && status.phase_last)
                begin
                    state_next = cfs_pkg::ST_TAIL;
                end
            end
            cfs_pkg::ST_TAIL:
            begin
                if (advance && status.phase_last)
                begin
                    state_next = cfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cfs_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: request handshake and datapath commands.
    always_comb
    begin
        in_ready = !busy;
        cmd.load = !busy && in_valid;
        cmd.step = advance;
        unique case (state_reg)
            cfs_pkg::ST_DATA: cmd.sel = cfs_pkg::SRC_DATA;
            cfs_pkg::ST_CRC:  cmd.sel = cfs_pkg::SRC_CRC;
            cfs_pkg::ST_TAIL: cmd.sel = cfs_pkg::SRC_TAIL;
            default:          cmd.sel = cfs_pkg::SRC_HDR;
        endcase
    end

endmodule

`default_nettype wire

// ===== src/cfs_datapath.sv =====
// Frame datapath: shift registers, CRC-15, chunk packing and output register.
`default_nettype none

module cfs_datapath #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire cfs_pkg::cmd_t       cmd,
    output cfs_pkg::status_t         status,
    input  wire logic [10:0]         frame_id,
    input  wire logic [3:0]          data_length,
    input  wire logic [63:0]         payload,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [7:0]               chunk_bits,
    output logic [3:0]               bit_count,
    output logic                     last
);

    localparam int PW = cfs_pkg::POS_W;

    logic [18:0]   header_reg;
    logic [63:0]   data_reg;
    logic [14:0]   crc_reg;
    logic [PW-1:0] pos_reg;
    logic [PW-1:0] nbits_reg;
    logic [7:0]    asm_reg;
    logic          out_valid_reg;
    logic [7:0]    chunk_reg;
    logic [3:0]    count_reg;
    logic          last_reg;

    logic [3:0]    len_sat;
    logic [PW-1:0] nbits_in;
    logic [PW-1:0] data_end;
    logic [PW-1:0] phase_end;
    logic          phase_last;
    logic          cur_bit;
    logic          fb;
    logic [PW-1:0] pos_next;
    logic [7:0]    asm_next;
    logic [3:0]    fill;
    logic          final_bit;
    logic          emit;
    logic          out_free;

    // Saturate the length code and size the data section.
    assign len_sat  = (data_length > 4'(MAX_DATA_BYTES)) ? 4'(MAX_DATA_BYTES) : data_length;
    assign nbits_in = {len_sat[3:0], 3'b000};

    // Section boundaries measured in frame bits.
    assign data_end = cfs_pkg::HDR_BITS + nbits_reg;

    always_comb
    begin
        unique case (cmd.sel)
            cfs_pkg::SRC_HDR:  phase_end = cfs_pkg::HDR_BITS;
            cfs_pkg::SRC_DATA: phase_end = data_end;
            cfs_pkg::SRC_CRC:  phase_end = data_end + cfs_pkg::CRC_BITS;
            cfs_pkg::SRC_TAIL: phase_end = data_end + cfs_pkg::CRC_BITS + cfs_pkg::TAIL_BITS;
            default:           phase_end = cfs_pkg::HDR_BITS;
        endcase
    end

    assign phase_last = (pos_reg == phase_end - 7'd1);

    // Current frame bit; the trailer is all ones but for the ack slot.
    always_comb
    begin
        unique case (cmd.sel)
            cfs_pkg::SRC_HDR:  cur_bit = header_reg[18];
            cfs_pkg::SRC_DATA: cur_bit = data_reg[63];
            cfs_pkg::SRC_CRC:  cur_bit = crc_reg[14];
            cfs_pkg::SRC_TAIL: cur_bit = (pos_reg != data_end + cfs_pkg::CRC_BITS + 7'd1);
            default:           cur_bit = 1'b1;
        endcase
    end

    assign fb = cur_bit ^ crc_reg[14];

    // Chunk packing; the final chunk is left aligned and zero padded.
    assign pos_next  = pos_reg + 7'd1;
    assign asm_next  = {asm_reg[6:0], cur_bit};
    assign fill      = (pos_next[2:0] == 3'd0) ? 4'd8 : {1'b0, pos_next[2:0]};
    assign final_bit = (cmd.sel == cfs_pkg::SRC_TAIL) && phase_last;
    assign emit      = (pos_next[2:0] == 3'd0) || final_bit;
    assign out_free  = !out_valid_reg || out_ready;

    assign status.step_ok    = !emit || out_free;
    assign status.phase_last = phase_last;
    assign status.data_empty = (nbits_reg == '0);

    // Frame control: bit counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.load)
        begin
            pos_reg <= '0;
        end
        else if (cmd.step)
        begin
            pos_reg <= pos_next;
        end
    end

    // Frame payload: shift registers, CRC and chunk assembly.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            header_reg <= {1'b0, frame_id, 3'b000, len_sat};
            data_reg   <= payload << (7'd64 - nbits_in);
            nbits_reg  <= nbits_in;
            crc_reg    <= '0;
            asm_reg    <= '0;
        end
        else if (cmd.step)
        begin
            asm_reg <= asm_next;
            unique case (cmd.sel)
                cfs_pkg::SRC_HDR:
                begin
                    header_reg <= {header_reg[17:0], 1'b0};
                    crc_reg    <= {crc_reg[13:0], 1'b0} ^ (fb ? cfs_pkg::CRC_POLY : 15'd0);
                end
                cfs_pkg::SRC_DATA:
                begin
                    data_reg <= {data_reg[62:0], 1'b0};
                    crc_reg  <= {crc_reg[13:0], 1'b0} ^ (fb ? cfs_pkg::CRC_POLY : 15'd0);
                end
                cfs_pkg::SRC_CRC:
                begin
                    crc_reg <= {crc_reg[13:0], 1'b0};
                end
                default:
                begin
                    crc_reg <= crc_reg;
                end
            endcase
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.step && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register beat contents.
    always_ff @(posedge clk)
    begin
        if (cmd.step && emit)
        begin
            chunk_reg <= asm_next << (4'd8 - fill);
            count_reg <= fill;
            last_reg  <= final_bit;
        end
    end

    assign out_valid  = out_valid_reg;
    assign chunk_bits = chunk_reg;
    assign bit_count  = count_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ===== src/can_frame_serializer_crc15_core.sv =====
// Timing: a frame of 47 + 8*L bits (L = saturated length) is shifted one bit per cycle
// while no held output beat stalls it, so a frame is 47 to 111 bits long; the rate is set
// by the single-bit shift and CRC loop, and a new request is taken only after the whole frame;
// a held output beat stalls the shift only when the next chunk is complete.
// Reset (rst_n, asynchronous, active low) clears the sequencer, bit counter and
// output valid; the block is ready for a request in the first cycle after reset.
`default_nettype none

module can_frame_serializer_crc15_core #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cfs_req_if.sink     req,
    cfs_chunk_if.source chunk
);

    cfs_pkg::cmd_t    cmd;
    cfs_pkg::status_t status;

    // Sequencer.
    cfs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Shift, CRC and chunk datapath.
    cfs_datapath #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .frame_id    (req.frame_id),
        .data_length (req.data_length),
        .payload     (req.payload),
        .out_valid   (chunk.valid),
        .out_ready   (chunk.ready),
        .chunk_bits  (chunk.chunk_bits),
        .bit_count   (chunk.bit_count),
        .last        (chunk.last)
    );

endmodule

`default_nettype wire

// ===== test/cfs_chunk_monitor.sv =====
// Watches both channels of the CAN frame serializer, predicts each frame's chunks and checks them.
`timescale 1ns / 1ps

module cfs_chunk_monitor (
    input  logic  clk,
    input  logic  rst_n,
    cfs_req_if    req,
    cfs_chunk_if  chunk,
    output int    fail_count,
    output int    pending
);

    // Frame layout as seen on the bus, before bit stuffing.
    localparam int          MAX_BYTES  = 8;
    localparam int          HEADER_LEN = 19;
    localparam int          TRAILER_LEN = 28;
    localparam logic [14:0] GEN_POLY   = 15'h4599;
    // CRC delimiter, ack slot, ack delimiter, then ten recessive bits.
    localparam logic [12:0] TAIL_BITS  = 13'b1_0_1_1111111111;

    typedef struct packed {
        logic [7:0] bits;
        logic [3:0] count;
        logic       last;
    } chunk_beat_t;

    chunk_beat_t expected_chunks[$];
    int          beat_index;

    initial
    begin
        fail_count = 0;
        pending    = 0;
        beat_index = 0;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] chunk beat %0d: %s", $realtime, beat_index, what);
        fail_count++;
    endtask

    // Build the bit stream of one frame and cut it into expected chunk beats.
    function automatic void frame_to_chunks(input logic [10:0] id, input logic [3:0] dlc,
                                            input logic [63:0] payload);
        logic [3:0]   len;
        logic [18:0]  header;
        logic [63:0]  data;
        logic [14:0]  crc;
        logic [127:0] stream;
        logic [7:0]   bits;
        logic         b;
        chunk_beat_t  beat;
        int           nbits;
        int           total;
        int           take;

        // A length code above the limit is replaced by the limit, in the header as well.
        len    = (dlc > MAX_BYTES) ? 4'(MAX_BYTES) : dlc;
        nbits  = 8 * int'(len);
        header = {1'b0, id, 3'b000, len};
        data   = (nbits == 0) ? 64'd0 : (payload << (64 - nbits));
        crc    = '0;
        stream = '0;

        // Header and data bits feed the CRC as they go out.
        for (int i = 0; i < HEADER_LEN + nbits; i++)
        begin
            if (i < HEADER_LEN)
                b = header[HEADER_LEN - 1 - i];
            else
                b = data[63 - (i - HEADER_LEN)];
            if (b ^ crc[14])
                crc = {crc[13:0], 1'b0} ^ GEN_POLY;
            else
                crc = {crc[13:0], 1'b0};
            stream = {stream[126:0], b};
        end
        stream = {stream[127-TRAILER_LEN:0], crc, TAIL_BITS};
        total  = HEADER_LEN + nbits + TRAILER_LEN;

        // Eight bits per beat, first bit in bit 7; the final beat is left aligned.
        for (int k = 0; k < total; k += 8)
        begin
            take = (total - k < 8) ? (total - k) : 8;
            bits = 8'(stream >> (total - k - take));
            bits = bits << (8 - take);
            beat.bits  = bits;
            beat.count = 4'(take);
            beat.last  = (k + 8 >= total);
            expected_chunks.push_back(beat);
        end
    endfunction

    // Predict on each accepted request, compare each accepted chunk with the oldest prediction.
    always @(posedge clk)
    begin : compare
        chunk_beat_t want;
        if (rst_n)
        begin
            if (req.valid && req.ready)
            begin
                frame_to_chunks(req.frame_id, req.data_length, req.payload);
            end
            if (chunk.valid && chunk.ready)
            begin
                if (expected_chunks.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat bits=%02h count=%0d last=%0b",
                                              chunk.chunk_bits, chunk.bit_count, chunk.last));
                end
                else
                begin
                    want = expected_chunks.pop_front();
                    if (chunk.chunk_bits !== want.bits)
                        report_mismatch($sformatf("chunk_bits %02h, expected %02h",
                                                  chunk.chunk_bits, want.bits));
                    if (chunk.bit_count !== want.count)
                        report_mismatch($sformatf("bit_count %0d, expected %0d",
                                                  chunk.bit_count, want.count));
                    if (chunk.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  chunk.last, want.last));
                end
                beat_index++;
            end
        end
        pending <= expected_chunks.size();
    end

endmodule

// ===== test/can_frame_serializer_crc15_core_test.sv =====
// Top of the CAN frame serializer testbench: clock, reset, frame requests, output stalls, verdict.
`timescale 1ns / 1ps

module can_frame_serializer_crc15_core_test;

    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 120;
    localparam int FRAMES_PER_PHASE = 75;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    int   fail_count;
    int   pending;

    cfs_req_if   req_if();
    cfs_chunk_if chunk_if();

    can_frame_serializer_crc15_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .chunk (chunk_if)
    );

    cfs_chunk_monitor monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_if),
        .chunk      (chunk_if),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Output side: random stalls at the current phase's rate.
    initial
    begin
        chunk_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            chunk_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // End the run when neither channel moves a beat for too long.
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (chunk_if.valid && chunk_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Offer one frame request, with a random gap in front, and hold it until accepted.
    task automatic send_frame(input logic [10:0] id, input logic [3:0] dlc,
                              input logic [63:0] payload);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_if.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_if.valid       <= 1'b1;
        req_if.frame_id    <= id;
        req_if.data_length <= dlc;
        req_if.payload     <= payload;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    // Stimulus and verdict.
    initial
    begin
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        rst_n              = 1'b0;
        req_if.valid       <= 1'b0;
        req_if.frame_id    <= '0;
        req_if.data_length <= '0;
        req_if.payload     <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every length code, including the ones above the limit, with extreme fields.
        for (int dlc = 0; dlc < 16; dlc++)
        begin
            case (dlc % 4)
                0: send_frame(11'h000, 4'(dlc), 64'h0000_0000_0000_0000);
                1: send_frame(11'h7FF, 4'(dlc), 64'hFFFF_FFFF_FFFF_FFFF);
                2: send_frame(11'h555, 4'(dlc), 64'hA5A5_A5A5_A5A5_A5A5);
                default: send_frame(11'h2AA, 4'(dlc), 64'h0123_4567_89AB_CDEF);
            endcase
        end
        // Alternating identifier and payload bits at full length.
        send_frame(11'h555, 4'd8, 64'hAAAA_AAAA_AAAA_AAAA);
        send_frame(11'h2AA, 4'd8, 64'h5555_5555_5555_5555);
        // Payload bits above the sent bytes must not show up or touch the CRC.
        send_frame(11'h123, 4'd3, 64'hFFFF_FFFF_FF00_0000);
        // Zero length with a full payload: header and CRC only.
        send_frame(11'h7FF, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);

        // Random frames under four idling patterns.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 80;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 80;
                end
                default:
                begin
                    send_idle_pct  = 29;
                    recv_stall_pct = 29;
                end
            endcase
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
            begin
                send_frame(11'($urandom_range(2047)), 4'($urandom_range(15)),
                           {$urandom, $urandom});
            end
        end

        // Drain: the monitor's pending count is registered, so it lags the edge that moves a beat.
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
